// ----- design/pcld_pkg.sv -----
// Package for the page cache LFU directory: constants, status codes, types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pcld_pkg;
  localparam int Ways       = 8;
  localparam int WayBits    = $clog2(Ways);
  localparam int PageBits   = 12;
  localparam int MaxExtents = 16;
  localparam int ExtBits    = $clog2(MaxExtents);
  localparam int AddrBits   = 48;
  localparam int TagBits    = AddrBits - PageBits;
  localparam int CntBits    = 16;
  localparam int SizeBits   = 16;
  localparam int EcntBits   = 5;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_READ = 2'd1,
    REQ_FILL = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_NOEXT  = 3'd2,
    ST_DIRECT = 3'd3,
    ST_FILLOK = 3'd4,
    ST_FILLNG = 3'd5,
    ST_LOADED = 3'd6,
    ST_STRAY  = 3'd7
  } status_e;

  // Control states of the top level.
  typedef enum logic [2:0] {
    S_IDLE, S_EXT, S_DIR, S_UPD, S_OUT
  } state_e;

  // Extent table entry as held in the extent memory.
  typedef struct packed {
    logic [AddrBits-1:0] base;
    logic [AddrBits-1:0] len;
    logic [AddrBits-1:0] store;
  } extent_t;

  // Result of the extent walk handed to the directory.
  typedef struct packed {
    logic                found;
    logic [AddrBits-1:0] base;
    logic [AddrBits-1:0] store;
  } ext_res_t;
endpackage
`default_nettype wire

// ----- design/pcld_extent.sv -----
// Extent table memory and the sequential walk that finds the first matching extent.
// Depends on pcld_pkg.
`default_nettype none
module pcld_extent (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [pcld_pkg::ExtBits-1:0] wr_slot_i,
  input  wire pcld_pkg::extent_t            wr_data_i,
  input  wire logic                         start_i,
  input  wire logic [pcld_pkg::AddrBits-1:0] addr_i,
  input  wire logic [pcld_pkg::EcntBits-1:0] count_i,
  output logic                              done_o,
  output pcld_pkg::ext_res_t                res_o
);
  localparam int IdxW = pcld_pkg::ExtBits + 1;

  pcld_pkg::extent_t mem [pcld_pkg::MaxExtents];
  pcld_pkg::extent_t rd_q;
  logic [IdxW-1:0] idx_q, idx_d, lim;
  logic busy_q, busy_d, rv_q, rv_d, done_d;
  logic [pcld_pkg::AddrBits-1:0] off;
  logic hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i] <= wr_data_i;
    end
    rd_q <= mem[idx_q[pcld_pkg::ExtBits-1:0]];
  end

  always_comb begin
    if (count_i > pcld_pkg::EcntBits'(pcld_pkg::MaxExtents)) begin
      lim = IdxW'(pcld_pkg::MaxExtents);
    end else begin
      lim = IdxW'(count_i);
    end
    off = addr_i - rd_q.base;
    hit = (rd_q.base <= addr_i) && (off < rd_q.len);
  end

  // One entry is read per cycle; its compare runs the cycle after.
  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    rv_d   = 1'b0;
    done_d = 1'b0;
    res_o  = '{found: hit, base: rd_q.base, store: rd_q.store};
    if (start_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rv_q && hit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (idx_q >= lim) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_o.found = 1'b0;
      end else begin
        rv_d  = 1'b1;
        idx_d = idx_q + 1'b1;
      end
    end
    if (!(busy_q && rv_q && hit) && !(busy_q && idx_q >= lim)) begin
      res_o.found = 1'b0;
    end
    done_o = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
      rv_q   <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      rv_q   <= rv_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q) else $error("extent done without walk");
  a_found_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> rv_q) else $error("found without read data");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= IdxW'(pcld_pkg::MaxExtents))) else $error("index overrun");
endmodule
`default_nettype wire

// ----- design/page_cache_lfu_directory.sv -----
// Top level of the page cache LFU directory: handshakes, APB register,
// directory memory walk and result register. Depends on pcld_pkg, pcld_extent.
//
// Usage: one input word on in_valid_i/in_ready_o gives exactly one output word
// on out_valid_o/out_ready_i. Loads write the extent memory; reads walk the
// extent memory one entry per cycle (first match wins), then walk the 8-way
// directory memory one way per cycle to find a hit or the first way with the
// smallest use count; fill reports update the pending victim way.
// Loads, stray fills and unused requests go straight to the result word; a
// fill report against a pending miss first updates the directory. A read
// compares extent entries up to the first match (the clamped count when
// nothing matches); when it finds no extent or crosses its page it skips
// the directory walk, which ends at the hit way on a hit and covers every
// way on a miss. Response times are set by the single-port extent and
// directory memory walks.
// One item is in flight at a time: in_ready_o is high only while the block is
// idle with its output register empty, so the next word is taken only after
// the result word leaves.
// The result sits in an output register, so a stalled receiver holds the
// word there and the block takes no new word until it is taken.
// Reset clears the pending miss, the extent count and all directory valid
// bits (kept in flip-flops); invalid ways read as count zero. The extent
// memory is undefined until loaded. No clearing pass is needed.
`default_nettype none
module page_cache_lfu_directory (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [47:0] address_i,
  input  wire logic [15:0] read_size_i,
  input  wire logic [3:0]  extent_slot_i,
  input  wire logic [47:0] extent_span_i,
  input  wire logic [47:0] extent_store_offset_i,
  input  wire logic        fill_ok_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [2:0]       way_o,
  output logic [47:0]      store_offset_o,
  output logic [11:0]      page_offset_o,
  output logic [15:0]      length_o
);
  localparam int WB = pcld_pkg::WayBits;
  localparam int TB = pcld_pkg::TagBits;
  localparam int CB = pcld_pkg::CntBits;

  pcld_pkg::state_e state_q, state_d;
  logic [pcld_pkg::EcntBits-1:0] ecnt_q;

  // Latched input word.
  logic [1:0]  req_q;
  logic [47:0] addr_q;
  logic [15:0] size_q;
  logic        ok_q;

  // Directory memory: tag and use count per way; valid bits in flip-flops.
  typedef struct packed {
    logic [TB-1:0] tag;
    logic [CB-1:0] cnt;
  } dir_t;
  dir_t dir_mem [pcld_pkg::Ways];
  dir_t dir_rd_q;
  logic [pcld_pkg::Ways-1:0] valid_q;
  logic dir_we;
  logic [WB-1:0] dir_wa;
  dir_t dir_wd;

  logic [WB:0]   scan_q, scan_d;      // read address of directory walk
  logic          drv_q, drv_d;        // read data valid
  logic [WB-1:0] vict_q, vict_d;
  logic [CB-1:0] vcnt_q, vcnt_d;
  logic [WB-1:0] hway_q, hway_d;

  logic [WB-1:0] pway_q, pway_d;
  logic [TB-1:0] ppage_q, ppage_d;
  logic          pflag_q, pflag_d;

  pcld_pkg::ext_res_t eres_q, eres_d, ext_res;
  logic ext_start, ext_done;

  logic out_valid_q, out_valid_d;
  logic [2:0] st_q, st_d, w_q, w_d;
  logic [47:0] so_q, so_d;
  logic [11:0] po_q, po_d;
  logic [15:0] len_q, len_d;

  logic in_acc, cfg_wr;
  logic [WB-1:0] rd_way, cur_way;
  logic [CB-1:0] cur_cnt;
  logic [16:0] pend;
  logic [TB-1:0] page;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata     = (paddr[2] == 1'b0) ? {27'd0, ecnt_q} : 32'd0;
  assign in_ready_o = (state_q == pcld_pkg::S_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign page       = addr_q[47:12];
  // End of the read within its page; wide enough that no size wraps it.
  assign pend       = 17'(addr_q[11:0]) + 17'(size_q);

  pcld_extent u_ext (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && (req_type_i == pcld_pkg::REQ_LOAD)),
    .wr_slot_i (extent_slot_i),
    .wr_data_i ('{base: address_i, len: extent_span_i, store: extent_store_offset_i}),
    .start_i   (ext_start),
    .addr_i    (addr_q),
    .count_i   (ecnt_q),
    .done_o    (ext_done),
    .res_o     (ext_res)
  );

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    dir_rd_q <= dir_mem[rd_way];
  end

  assign rd_way  = (state_q == pcld_pkg::S_DIR) ? scan_q[WB-1:0] : pway_q;
  assign cur_way = scan_q[WB-1:0] - 1'b1;
  assign cur_cnt = valid_q[cur_way] ? dir_rd_q.cnt : '0;

  always_comb begin
    state_d = state_q;
    scan_d = scan_q; drv_d = 1'b0;
    vict_d = vict_q; vcnt_d = vcnt_q; hway_d = hway_q;
    pway_d = pway_q; ppage_d = ppage_q; pflag_d = pflag_q;
    eres_d = eres_q; ext_start = 1'b0;
    dir_we = 1'b0; dir_wa = pway_q; dir_wd = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    st_d = st_q; w_d = w_q; so_d = so_q; po_d = po_q; len_d = len_q;
    unique case (state_q)
      pcld_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            pcld_pkg::REQ_LOAD: state_d = pcld_pkg::S_OUT;
            pcld_pkg::REQ_READ: begin
              ext_start = 1'b1;
              state_d = pcld_pkg::S_EXT;
            end
            pcld_pkg::REQ_FILL: state_d = pflag_q ? pcld_pkg::S_UPD : pcld_pkg::S_OUT;
            default: state_d = pcld_pkg::S_OUT;
          endcase
        end
      end
      pcld_pkg::S_EXT: begin
        if (ext_done) begin
          eres_d = ext_res;
          if (!ext_res.found || pend > 17'd4096) begin
            state_d = pcld_pkg::S_OUT;
          end else begin
            state_d = pcld_pkg::S_DIR;
            scan_d = '0;
            hway_d = '0;
            vict_d = '0;
            vcnt_d = '1;
          end
        end
      end
      pcld_pkg::S_DIR: begin
        // Way scan_q-1 data arrives now; way scan_q is being read.
        if (scan_q != (WB+1)'(pcld_pkg::Ways)) begin
          scan_d = scan_q + 1'b1;
          drv_d  = 1'b1;
        end
        if (drv_q) begin
          if (valid_q[cur_way] && dir_rd_q.tag == page) begin
            hway_d = cur_way;
            dir_we = 1'b1;
            dir_wa = cur_way;
            dir_wd = '{tag: dir_rd_q.tag,
                       cnt: (dir_rd_q.cnt == '1) ? dir_rd_q.cnt : dir_rd_q.cnt + 1'b1};
            st_d = pcld_pkg::ST_HIT;
            state_d = pcld_pkg::S_OUT;
          end else if (cur_way == '0 || cur_cnt < vcnt_q) begin
            vict_d = cur_way;
            vcnt_d = cur_cnt;
          end
        end
        if (!drv_q && scan_q == (WB+1)'(pcld_pkg::Ways)) begin
          st_d = pcld_pkg::ST_MISS;
          pway_d = vict_q;
          ppage_d = page;
          pflag_d = 1'b1;
          state_d = pcld_pkg::S_OUT;
        end else if (state_d != pcld_pkg::S_OUT) begin
          st_d = pcld_pkg::ST_MISS;
        end
      end
      pcld_pkg::S_UPD: begin
        pflag_d = 1'b0;
        dir_we = 1'b1;
        dir_wa = pway_q;
        dir_wd = '{tag: ok_q ? ppage_q : dir_rd_q.tag, cnt: ok_q ? CB'(1) : '0};
        state_d = pcld_pkg::S_OUT;
      end
      pcld_pkg::S_OUT: begin
        out_valid_d = 1'b1;
        state_d = pcld_pkg::S_IDLE;
        w_d = '0; so_d = '0; po_d = '0; len_d = '0;
        unique case (req_q)
          pcld_pkg::REQ_LOAD: st_d = pcld_pkg::ST_LOADED;
          pcld_pkg::REQ_READ: begin
            po_d = addr_q[11:0];
            len_d = size_q;
            if (!eres_q.found) begin
              st_d = pcld_pkg::ST_NOEXT;
              po_d = '0;
              len_d = '0;
            end else if (pend > 17'd4096) begin
              st_d = pcld_pkg::ST_DIRECT;
              so_d = addr_q - eres_q.base + eres_q.store;
            end else if (st_q == pcld_pkg::ST_HIT) begin
              w_d = hway_q;
            end else begin
              w_d = pway_q;
              so_d = {page, 12'd0} - eres_q.base + eres_q.store;
            end
          end
          pcld_pkg::REQ_FILL: begin
            if (st_q == pcld_pkg::ST_STRAY) begin
              st_d = pcld_pkg::ST_STRAY;
            end else begin
              w_d = pway_q;
              st_d = ok_q ? pcld_pkg::ST_FILLOK : pcld_pkg::ST_FILLNG;
              len_d = ok_q ? size_q : '0;
            end
          end
          default: st_d = pcld_pkg::ST_STRAY;
        endcase
      end
      default: state_d = pcld_pkg::S_IDLE;
    endcase
    if (state_q == pcld_pkg::S_IDLE && in_acc) begin
      st_d = (req_type_i == pcld_pkg::REQ_FILL && !pflag_q) ? pcld_pkg::ST_STRAY
                                                           : pcld_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_type_i;
      addr_q <= address_i;
      size_q <= read_size_i;
      ok_q   <= fill_ok_i;
    end
    w_q <= w_d; so_q <= so_d; po_q <= po_d; len_q <= len_d;
    vict_q <= vict_d; vcnt_q <= vcnt_d; hway_q <= hway_d;
    eres_q <= eres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcld_pkg::S_IDLE;
      ecnt_q <= '0;
      valid_q <= '0;
      scan_q <= '0;
      drv_q <= 1'b0;
      pway_q <= '0;
      ppage_q <= '0;
      pflag_q <= 1'b0;
      out_valid_q <= 1'b0;
      st_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        ecnt_q <= pwdata[4:0];
      end
      if (dir_we && state_q == pcld_pkg::S_UPD) begin
        valid_q[dir_wa] <= ok_q;
      end
      scan_q <= scan_d;
      drv_q <= drv_d;
      pway_q <= pway_d;
      ppage_q <= ppage_d;
      pflag_q <= pflag_d;
      out_valid_q <= out_valid_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = st_q;
  assign way_o          = w_q;
  assign store_offset_o = so_q;
  assign page_offset_o  = po_q;
  assign length_o       = len_q;

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pcld_pkg::S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_fill_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcld_pkg::S_UPD) |-> pflag_q) else $error("fill without pending miss");
endmodule
`default_nettype wire

// ----- bench/page_cache_lfu_directory_tb.sv -----
// Testbench for page_cache_lfu_directory: directed and random words with a scoreboard.
// It drives the valid/ready channels and the APB register, and checks every result word.
// Depends on pcld_pkg and the block's RTL.
`default_nettype none
module page_cache_lfu_directory_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result word as the block presents it.
  typedef struct {
    pcld_pkg::status_e status;
    logic [2:0]  way;
    logic [47:0] store_offset;
    logic [11:0] page_offset;
    logic [15:0] length;
  } dir_word_t;

  // The scoreboard holds its own copy of the extent table, the directory and the
  // pending miss. It works out the result word of every accepted input word and
  // queues it until the block delivers the matching word.
  class dir_scoreboard;
    logic [47:0] ext_base  [pcld_pkg::MaxExtents];
    logic [47:0] ext_len   [pcld_pkg::MaxExtents];
    logic [47:0] ext_store [pcld_pkg::MaxExtents];
    logic [35:0] tag_page  [pcld_pkg::Ways];
    logic        tag_valid [pcld_pkg::Ways];
    logic [15:0] use_cnt   [pcld_pkg::Ways];
    logic [2:0]  pend_way;
    logic [35:0] pend_page;
    logic        pend;
    logic [4:0]  ext_count;
    dir_word_t   awaited[$];
    int          fails;

    function new();
      for (int i = 0; i < pcld_pkg::Ways; i++) begin
        tag_page[i] = '0;
        tag_valid[i] = 1'b0;
        use_cnt[i] = '0;
      end
      pend_way = '0;
      pend_page = '0;
      pend = 1'b0;
      ext_count = '0;
      fails = 0;
    endfunction

    function void set_count(logic [31:0] v);
      ext_count = v[4:0];
    endfunction

    // Predicts the result word of one accepted input word and queues it.
    function void note_input(pcld_pkg::req_e req, logic [47:0] addr, logic [15:0] size,
                             logic [3:0] slot, logic [47:0] span,
                             logic [47:0] store, logic ok);
      dir_word_t w;
      int hit_ext;
      int n;
      int victim;
      logic [12:0] reach;
      logic [35:0] page;
      w.status = pcld_pkg::ST_STRAY;
      w.way = '0;
      w.store_offset = '0;
      w.page_offset = '0;
      w.length = '0;
      hit_ext = -1;
      victim = 0;
      if (req == pcld_pkg::REQ_LOAD) begin
        ext_base[slot] = addr;
        ext_len[slot] = span;
        ext_store[slot] = store;
        w.status = pcld_pkg::ST_LOADED;
      end else if (req == pcld_pkg::REQ_READ) begin
        n = (ext_count > pcld_pkg::MaxExtents) ? pcld_pkg::MaxExtents : ext_count;
        for (int i = 0; i < n; i++) begin
          if (hit_ext < 0 && ext_base[i] <= addr && (addr - ext_base[i]) < ext_len[i])
            hit_ext = i;
        end
        if (hit_ext < 0) begin
          w.status = pcld_pkg::ST_NOEXT;
        end else begin
          w.page_offset = addr[11:0];
          w.length = size;
          reach = {1'b0, addr[11:0]};
          page = addr[47:12];
          if (32'(reach) + 32'(size) > 32'd4096) begin
            // A read that crosses its page goes straight to the store.
            w.status = pcld_pkg::ST_DIRECT;
            w.store_offset = addr - ext_base[hit_ext] + ext_store[hit_ext];
          end else begin
            w.status = pcld_pkg::ST_MISS;
            for (int i = 0; i < pcld_pkg::Ways; i++) begin
              if (w.status == pcld_pkg::ST_MISS) begin
                if (tag_valid[i] && tag_page[i] == page) begin
                  if (use_cnt[i] != 16'hFFFF) use_cnt[i]++;
                  w.status = pcld_pkg::ST_HIT;
                  w.way = 3'(i);
                end else if (use_cnt[victim] > use_cnt[i]) begin
                  victim = i;
                end
              end
            end
            if (w.status == pcld_pkg::ST_MISS) begin
              pend_way = 3'(victim);
              pend_page = page;
              pend = 1'b1;
              w.way = 3'(victim);
              w.store_offset = {page, 12'h000} - ext_base[hit_ext] + ext_store[hit_ext];
            end
          end
        end
      end else if (req == pcld_pkg::REQ_FILL && pend) begin
        pend = 1'b0;
        w.way = pend_way;
        if (ok) begin
          tag_page[pend_way] = pend_page;
          tag_valid[pend_way] = 1'b1;
          use_cnt[pend_way] = 16'd1;
          w.status = pcld_pkg::ST_FILLOK;
          w.length = size;
        end else begin
          tag_valid[pend_way] = 1'b0;
          use_cnt[pend_way] = '0;
          w.status = pcld_pkg::ST_FILLNG;
        end
      end
      awaited.push_back(w);
    endfunction

    // Compares one delivered word with the oldest prediction.
    function void check_result(dir_word_t got);
      dir_word_t w;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word status=%0d", $realtime, got.status);
        fails++;
        return;
      end
      w = awaited.pop_front();
      if (got.status !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, w.status, got.status);
        fails++;
      end
      if (got.way !== w.way) begin
        $display("%0t: way expected %0d actual %0d", $realtime, w.way, got.way);
        fails++;
      end
      if (got.store_offset !== w.store_offset) begin
        $display("%0t: store_offset expected %h actual %h", $realtime,
                 w.store_offset, got.store_offset);
        fails++;
      end
      if (got.page_offset !== w.page_offset) begin
        $display("%0t: page_offset expected %h actual %h", $realtime,
                 w.page_offset, got.page_offset);
        fails++;
      end
      if (got.length !== w.length) begin
        $display("%0t: length expected %0d actual %0d", $realtime, w.length, got.length);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pcld_pkg::req_e req_type_i = pcld_pkg::REQ_LOAD;
  logic [47:0] address_i = '0;
  logic [15:0] read_size_i = '0;
  logic [3:0]  extent_slot_i = '0;
  logic [47:0] extent_span_i = '0;
  logic [47:0] extent_store_offset_i = '0;
  logic        fill_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [2:0]  way_o;
  logic [47:0] store_offset_o;
  logic [11:0] page_offset_o;
  logic [15:0] length_o;

  dir_scoreboard sb = new();
  bit no_idle = 1'b0;    // stretches where neither side idles
  bit hold_req = 1'b0;   // asks the receiver for one long stall

  page_cache_lfu_directory dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .req_type_i, .address_i, .read_size_i,
    .extent_slot_i, .extent_span_i, .extent_store_offset_i, .fill_ok_i,
    .out_valid_o, .out_ready_i, .status_o, .way_o, .store_offset_o,
    .page_offset_o, .length_o
  );

  always #2 clk_i = ~clk_i;

  // Gap lengths: mostly short, now and then long.
  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word, waits for its acceptance, then maybe idles. Called and
  // returns at a falling edge.
  task automatic send_word(pcld_pkg::req_e req, logic [47:0] addr, logic [15:0] size,
                           logic [3:0] slot, logic [47:0] span,
                           logic [47:0] store, logic ok);
    int gap;
    req_type_i = req;
    address_i = addr;
    read_size_i = size;
    extent_slot_i = slot;
    extent_span_i = span;
    extent_store_offset_i = store;
    fill_ok_i = ok;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(req, addr, size, slot, span, store, ok);
    @(negedge clk_i);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_read(logic [47:0] addr, logic [15:0] size);
    send_word(pcld_pkg::REQ_READ, addr, size, 4'(0), 48'($urandom), 48'($urandom),
              1'($urandom));
  endtask

  task automatic send_fill(logic ok, logic [15:0] size);
    send_word(pcld_pkg::REQ_FILL, 48'({$urandom, $urandom}), size, 4'($urandom),
              48'({$urandom, $urandom}), 48'({$urandom, $urandom}), ok);
  endtask

  // Loads a slot of the clustered layout: each extent spans a few pages near
  // the bottom of the address space, with overlaps so first match matters.
  task automatic load_cluster(logic [3:0] slot);
    send_word(pcld_pkg::REQ_LOAD, 48'(slot) * 48'h8000 + 48'($urandom_range(0, 4095)),
              16'($urandom), slot, 48'($urandom_range(0, 32'h18000)),
              48'({$urandom, $urandom}), 1'($urandom));
  endtask

  // Waits until every predicted word has come back, plus the block's latency.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Writes the extent count over APB; only called while the block is idle.
  task automatic write_count(logic [31:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = '0;
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_count(v);
  endtask

  // Picks a read address that mostly falls in a small set of pages so the
  // directory sees hits, evictions and reuse.
  function automatic logic [47:0] pick_addr();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 48'({$urandom, $urandom});
    if (r == 1) return 48'hFFFF_FFFF_F000 + 48'($urandom_range(0, 4095));
    return 48'($urandom_range(0, 2)) * 48'h8000 + 48'($urandom_range(0, 32'h7FFF));
  endfunction

  function automatic logic [15:0] pick_size(logic [47:0] addr);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'(4096 - addr[11:0]);
    if (r == 2) return 16'(4097 - addr[11:0]);
    return 16'($urandom_range(0, 64));
  endfunction

  // One phase of random words. Most are read/fill sequences; the rest is
  // reloads, stray fills and unused requests.
  task automatic random_phase(int count);
    int r;
    logic [47:0] a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (sb.pend && r < 60) begin
        send_fill($urandom_range(0, 6) != 0, 16'($urandom));
      end else if (r < 75) begin
        a = pick_addr();
        send_read(a, pick_size(a));
      end else if (r < 85) begin
        a = pick_addr();
        send_read(a, 16'($urandom_range(0, 16)));
      end else if (r < 91) begin
        if ($urandom_range(0, 3) == 0)
          send_word(pcld_pkg::REQ_LOAD, 48'({$urandom, $urandom}), 16'($urandom),
                    4'($urandom), 48'({$urandom, $urandom}),
                    48'({$urandom, $urandom}), 1'($urandom));
        else
          load_cluster(4'($urandom));
      end else if (r < 96) begin
        send_fill(1'($urandom), 16'($urandom));
      end else begin
        send_word(pcld_pkg::REQ_NONE, 48'({$urandom, $urandom}), 16'($urandom),
                  4'($urandom), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 1'($urandom));
      end
    end
  endtask

  // Receiver: samples at the rising edge, changes ready at the falling edge.
  // A long stall asked by the stimulus is counted out here.
  initial begin : receiver
    dir_word_t got;
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = pcld_pkg::status_e'(status_o);
        got.way = way_o;
        got.store_offset = store_offset_o;
        got.page_offset = page_offset_o;
        got.length = length_o;
        sb.check_result(got);
      end
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_wait = 400;
      end
      if (rx_wait > 0) begin
        out_ready_i = 1'b0;
        rx_wait--;
      end else begin
        out_ready_i = 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) rx_wait = gap_len();
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("** page_cache_lfu_directory: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // With no extents searched, a read finds nothing; stray fill and an unused
    // request change nothing.
    send_read(48'h0000_0000_1000, 16'd8);
    send_fill(1'b1, 16'd5);
    send_word(pcld_pkg::REQ_NONE, '1, '1, '1, '1, '1, 1'b1);
    // Fill the whole extent table; the last slot sits at the very top with
    // the largest span and store offset, so offsets wrap.
    for (int s = 0; s < pcld_pkg::MaxExtents - 1; s++) load_cluster(4'(s));
    send_word(pcld_pkg::REQ_LOAD, 48'hFFFF_FFFF_F000, 16'd0, 4'hF, '1, '1, 1'b0);
    drain();
    write_count(32'd16);

    send_read(48'hFFFF_FFFF_FFFF, 16'd0);        // top extent, miss
    send_fill(1'b1, 16'hFFFF);
    send_read(48'hFFFF_FFFF_FFFF, 16'd1);        // hit
    send_read(48'hFFFF_FFFF_F800, 16'hFFFF);     // crosses the page: direct
    send_read(48'hFFFF_FFFF_F000, 16'd4096);     // exactly one page: not direct
    send_fill(1'b0, 16'd3);                      // no miss pending: stray fill
    send_read(48'h0000_0000_8010, 16'd4);        // miss
    send_read(48'h0000_0001_0010, 16'd4);        // a second miss replaces the first
    send_fill(1'b1, 16'd12);
    send_read(48'h0000_0001_0020, 16'd0);
    drain();

    no_idle = 1'b1;
    random_phase(150);
    drain();
    no_idle = 1'b0;
    write_count(32'd1);
    random_phase(150);
    drain();
    write_count(32'd0);
    random_phase(40);
    drain();
    write_count(32'd5);
    random_phase(100);
    // The receiver stalls for a long stretch while words keep being offered.
    hold_req = 1'b1;
    random_phase(100);
    drain();
    write_count(32'd16);
    random_phase(200);
    drain();
    write_count(32'($urandom_range(1, 16)));
    random_phase(170);
    drain();

    if (sb.fails == 0 && sb.awaited.size() == 0) begin
      $display("** page_cache_lfu_directory: PASSED **");
    end else begin
      $display("** page_cache_lfu_directory: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
